>>> rtl/mlt_pkg.sv
// ----------------------------------------------------------------------------
// mlt_pkg
// Types and codes shared by the MAC learning table.
// ----------------------------------------------------------------------------
package mlt_pkg;

   localparam int KEY_W = 60;

   localparam logic [2:0] FN_LEARN      = 3'd0;
   localparam logic [2:0] FN_ADD_STATIC = 3'd1;
   localparam logic [2:0] FN_LOOKUP     = 3'd2;
   localparam logic [2:0] FN_REMOVE     = 3'd3;
   localparam logic [2:0] FN_SWEEP      = 3'd4;

   localparam logic [3:0] ST_INSERTED  = 4'd0;
   localparam logic [3:0] ST_REFRESHED = 4'd1;
   localparam logic [3:0] ST_MOVED     = 4'd2;
   localparam logic [3:0] ST_FULL      = 4'd3;
   localparam logic [3:0] ST_CONFLICT  = 4'd4;
   localparam logic [3:0] ST_REJECTED  = 4'd5;
   localparam logic [3:0] ST_HIT       = 4'd6;
   localparam logic [3:0] ST_MISS      = 4'd7;
   localparam logic [3:0] ST_REMOVED   = 4'd8;
   localparam logic [3:0] ST_NOT_FOUND = 4'd9;
   localparam logic [3:0] ST_SWEPT     = 4'd10;

   localparam logic REG_CAPACITY = 1'b0;
   localparam logic REG_LIFETIME = 1'b1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_MATCH,
      S_DECIDE
   } state_type;

   typedef struct packed {
      logic write;
      logic clear;
   } cell_cmd_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [7:0]       port;
      logic             pinned;
   } cell_data_type;

   typedef struct packed {
      logic valid;
      logic match;
      logic expire;
      logic pinned;
   } cell_stat_type;

endpackage

>>> rtl/mlt_req_if.sv
// ----------------------------------------------------------------------------
// mlt_req_if
// Request channel: valid/ready plus one request word.
// ----------------------------------------------------------------------------
interface mlt_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  func;
   logic [11:0] vlan_id;
   logic [47:0] mac_addr;
   logic [7:0]  port;
   logic [31:0] time_now;

   modport source (output valid, func, vlan_id, mac_addr, port, time_now, input ready);
   modport sink   (input valid, func, vlan_id, mac_addr, port, time_now, output ready);
endinterface

>>> rtl/mlt_rsp_if.sv
// ----------------------------------------------------------------------------
// mlt_rsp_if
// Response channel: valid/ready plus one result word.
// ----------------------------------------------------------------------------
interface mlt_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  status;
   logic        found;
   logic [7:0]  entry_port;
   logic        entry_static;
   logic [31:0] entry_time;
   logic [6:0]  removed_count;

   modport source (output valid, status, found, entry_port, entry_static, entry_time,
                   removed_count, input ready);
   modport sink   (input valid, status, found, entry_port, entry_static, entry_time,
                   removed_count, output ready);
endinterface

>>> rtl/mlt_cell.sv
// ----------------------------------------------------------------------------
// mlt_cell
// One table entry: stores key, port, type and stamp; registers key match
// and expiry against the broadcast request every cycle.
// ----------------------------------------------------------------------------
module mlt_cell #(
   parameter int TIME_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  mlt_pkg::cell_cmd_type    cmd,
   input  mlt_pkg::cell_data_type   data,
   input  logic [TIME_BITS-1:0]     stamp_in,
   input  logic [TIME_BITS-1:0]     now,
   input  logic [31:0]              lifetime,
   output mlt_pkg::cell_stat_type   stat,
   output logic [7:0]               port_out,
   output logic [TIME_BITS-1:0]     stamp_out
);
   import mlt_pkg::*;

   localparam int WW = (TIME_BITS > 32) ? TIME_BITS : 32;

   logic                 valid_ff, valid_in;
   logic [KEY_W-1:0]     key_ff;
   logic [7:0]           port_ff;
   logic                 static_ff;
   logic [TIME_BITS-1:0] stamp_ff;
   logic                 match_ff, match_in;
   logic                 expire_ff, expire_in;
   logic [TIME_BITS-1:0] age;

   always_comb begin
      valid_in = valid_ff;
      if (cmd.clear) valid_in = 1'b0;
      if (cmd.write) valid_in = 1'b1;
      age       = now - stamp_ff;
      match_in  = valid_ff && (key_ff == data.key);
      expire_in = valid_ff && !static_ff && (now >= stamp_ff) &&
                  (WW'(age) >= WW'(lifetime));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         match_ff  <= 1'b0;
         expire_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         match_ff  <= match_in;
         expire_ff <= expire_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write) begin
         key_ff    <= data.key;
         port_ff   <= data.port;
         static_ff <= data.pinned;
         stamp_ff  <= stamp_in;
      end
   end

   assign stat.valid  = valid_ff;
   assign stat.match  = match_ff;
   assign stat.expire = expire_ff;
   assign stat.pinned = static_ff;
   assign port_out    = port_ff;
   assign stamp_out   = stamp_ff;
endmodule

>>> rtl/mac_learning_table.sv
// ----------------------------------------------------------------------------
// mac_learning_table
// Fully associative VLAN+MAC forwarding table with aging, built as a row
// of entry cells under a small request sequencer.
// ----------------------------------------------------------------------------
//   channel   dir  handshake        word
//   req_chan  in   valid/ready      func, vlan_id, mac_addr, port, time_now
//   rsp_chan  out  valid/ready      status, found, entry_port, entry_static,
//                                   entry_time, removed_count
//   csr_*     in   APB write/read   capacity @0, lifetime @4
//
// Each request passes through accept, cell match/expiry compare (registered
// in every cell), decide and entry update with the result registered.
// Reset clears all cell valid bits directly; no clearing pass.
// A stalled response holds the sequencer in the decide step; the next
// request is accepted while a response waits.
// ----------------------------------------------------------------------------
module mac_learning_table #(
   parameter int DEPTH     = 64,
   parameter int TIME_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   mlt_req_if.sink     req_chan,
   mlt_rsp_if.source   rsp_chan,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import mlt_pkg::*;

   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > 7) ? CW : 7;
   localparam int TW   = (TIME_BITS > 32) ? TIME_BITS : 32;

   // configuration
   logic [6:0]  cap_ff;
   logic [31:0] life_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_LIFETIME) ? life_ff : {25'd0, cap_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff  <= 7'd64;
         life_ff <= 32'd300;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         if (csr_paddr[2] == REG_CAPACITY) cap_ff <= csr_pwdata[6:0];
         else                              life_ff <= csr_pwdata;
      end
   end

   // request register
   state_type      state_ff, state_in;
   logic [2:0]     func_ff;
   logic [11:0]    vlan_ff;
   logic [47:0]    mac_ff;
   logic [7:0]     port_ff;
   logic [TIME_BITS-1:0] now_ff;
   logic [TW-1:0]  now_wide;

   assign now_wide = TW'(req_chan.time_now);
   assign req_chan.ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         func_ff <= req_chan.func;
         vlan_ff <= req_chan.vlan_id;
         mac_ff  <= req_chan.mac_addr;
         port_ff <= req_chan.port;
         now_ff  <= now_wide[TIME_BITS-1:0];
      end
   end

   // cells
   cell_data_type        bcast;
   logic [TIME_BITS-1:0] bstamp;
   cell_cmd_type         cmd   [DEPTH];
   cell_stat_type        stat  [DEPTH];
   logic [7:0]           cport [DEPTH];
   logic [TIME_BITS-1:0] cstamp[DEPTH];
   logic [DEPTH-1:0]     wr_vec, clr_vec;

   assign bcast.key    = {vlan_ff, mac_ff};
   assign bcast.port   = port_ff;
   assign bcast.pinned = (func_ff == FN_ADD_STATIC);
   assign bstamp       = bcast.pinned ? '0 : now_ff;

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      assign cmd[g].write = wr_vec[g];
      assign cmd[g].clear = clr_vec[g];
      mlt_cell #(.TIME_BITS(TIME_BITS)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd[g]),
         .data      (bcast),
         .stamp_in  (bstamp),
         .now       (now_ff),
         .lifetime  (life_ff),
         .stat      (stat[g]),
         .port_out  (cport[g]),
         .stamp_out (cstamp[g])
      );
   end

   // reductions over the row
   logic [DEPTH-1:0]     valid_vec, match_vec, expire_vec, free_1h;
   logic                 hit, hit_static, has_free;
   logic [7:0]           hit_port;
   logic [TIME_BITS-1:0] hit_stamp;
   logic [CW-1:0]        used;
   logic [CW-1:0]        swept;

   always_comb begin
      hit_static = 1'b0;
      hit_port   = '0;
      hit_stamp  = '0;
      for (int i = 0; i < DEPTH; i++) begin
         valid_vec[i]  = stat[i].valid;
         match_vec[i]  = stat[i].match;
         expire_vec[i] = stat[i].expire;
         hit_static    = hit_static | (stat[i].match & stat[i].pinned);
         hit_port      = hit_port  | (stat[i].match ? cport[i]  : '0);
         hit_stamp     = hit_stamp | (stat[i].match ? cstamp[i] : '0);
      end
      hit      = |match_vec;
      has_free = |(~valid_vec);
      free_1h  = ~valid_vec & (valid_vec + DEPTH'(1));
      used     = CW'($countones(valid_vec));
      swept    = CW'($countones(expire_vec));
   end

   // response register
   logic        rsp_valid_ff;
   logic [3:0]  status_ff, status_in;
   logic        found_ff, found_in;
   logic [7:0]  eport_ff, eport_in;
   logic        estatic_ff, estatic_in;
   logic [31:0] etime_ff, etime_in;
   logic [6:0]  rcount_ff, rcount_in;
   logic        out_free, advance;
   logic [TW-1:0] stamp_wide;
   logic        mac_ok;

   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign advance    = (state_ff == S_DECIDE) && out_free;
   assign stamp_wide = TW'(hit_stamp);
   assign mac_ok     = (mac_ff != '0) && !mac_ff[40];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:   if (req_chan.valid) state_in = S_MATCH;
         S_MATCH:  state_in = S_DECIDE;
         S_DECIDE: if (out_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      wr_vec     = '0;
      clr_vec    = '0;
      status_in  = ST_REJECTED;
      found_in   = 1'b0;
      eport_in   = '0;
      estatic_in = 1'b0;
      etime_in   = '0;
      rcount_in  = '0;
      case (func_ff)
         FN_LEARN, FN_ADD_STATIC: begin
            if (mac_ok) begin
               if (!hit) begin
                  if (!has_free || (CMPW'(used) >= CMPW'(cap_ff))) begin
                     status_in = ST_FULL;
                  end else begin
                     status_in = ST_INSERTED;
                     wr_vec    = free_1h;
                  end
               end else if (hit_static && !bcast.pinned) begin
                  status_in = (hit_port != port_ff) ? ST_CONFLICT : ST_REFRESHED;
               end else begin
                  status_in = (hit_port != port_ff) ? ST_MOVED : ST_REFRESHED;
                  wr_vec    = match_vec;
               end
            end
         end
         FN_LOOKUP: begin
            if (hit) begin
               status_in  = ST_HIT;
               found_in   = 1'b1;
               eport_in   = hit_port;
               estatic_in = hit_static;
               etime_in   = stamp_wide[31:0];
            end else begin
               status_in  = ST_MISS;
            end
         end
         FN_REMOVE: begin
            if (hit) begin
               status_in = ST_REMOVED;
               found_in  = 1'b1;
               clr_vec   = match_vec;
            end else begin
               status_in = ST_NOT_FOUND;
            end
         end
         FN_SWEEP: begin
            status_in = ST_SWEPT;
            rcount_in = 7'(swept);
            clr_vec   = expire_vec;
         end
         default: status_in = ST_REJECTED;
      endcase
      if (!advance) begin
         wr_vec  = '0;
         clr_vec = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (advance)             rsp_valid_ff <= 1'b1;
         else if (rsp_chan.ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         status_ff  <= status_in;
         found_ff   <= found_in;
         eport_ff   <= eport_in;
         estatic_ff <= estatic_in;
         etime_ff   <= etime_in;
         rcount_ff  <= rcount_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = status_ff;
   assign rsp_chan.found         = found_ff;
   assign rsp_chan.entry_port    = eport_ff;
   assign rsp_chan.entry_static  = estatic_ff;
   assign rsp_chan.entry_time    = etime_ff;
   assign rsp_chan.removed_count = rcount_ff;
endmodule

>>> rtl/mlt_checker.sv
// ----------------------------------------------------------------------------
// mlt_checker
// Port-level checks on the MAC learning table response channel.
// ----------------------------------------------------------------------------
module mlt_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [3:0]  status,
   input logic        found,
   input logic [7:0]  entry_port,
   input logic [31:0] entry_time,
   input logic [6:0]  removed_count
);
   import mlt_pkg::*;

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(status))
      else $error("stalled response changed");

   a_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (found == (status == ST_HIT || status == ST_REMOVED)))
      else $error("found flag disagrees with status");

   a_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status != ST_HIT |-> entry_port == '0 && entry_time == '0)
      else $error("entry fields set without a hit");

   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status != ST_SWEPT |-> removed_count == '0)
      else $error("removed count set outside a sweep");
endmodule

bind mac_learning_table mlt_checker u_mlt_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .status        (rsp_chan.status),
   .found         (rsp_chan.found),
   .entry_port    (rsp_chan.entry_port),
   .entry_time    (rsp_chan.entry_time),
   .removed_count (rsp_chan.removed_count)
);
